// File: rtl/core/dau_pkg.sv
// Shared types, constants and helpers of the duration arithmetic unit.
`timescale 1ns / 1ps
package dau_pkg;

	localparam int DAY_BITS = 16;
	localparam longint unsigned DAY_LIMIT = 64'd1 << DAY_BITS;
	localparam longint unsigned SEC_PER_DAY = 64'd86400;
	localparam longint unsigned MAX_SEC = DAY_LIMIT * SEC_PER_DAY - 64'd1;

	// total-seconds width and widths of the successive quotients
	localparam int SEC_W = $clog2(MAX_SEC + 64'd1);
	localparam int M1_W = SEC_W - 5;
	localparam int H1_W = M1_W - 5;
	localparam int DQ_W = H1_W - 4;
	localparam int K_W = 16;

	localparam int DIV_STEP = 3;
	localparam int DIV_STAGES = (SEC_W + DIV_STEP - 1) / DIV_STEP;
	localparam int DIV_QW = DIV_STAGES * DIV_STEP;

	// reciprocals for the constant divisions, floor(2^W / c)
	localparam logic [SEC_W-1:0] R60_N = SEC_W'((64'd1 << SEC_W) / 64'd60);
	localparam logic [M1_W-1:0] R60_M = M1_W'((64'd1 << M1_W) / 64'd60);
	localparam logic [H1_W-1:0] R24_H = H1_W'((64'd1 << H1_W) / 64'd24);

	localparam logic [SEC_W+K_W-1:0] MAX_WIDE = (SEC_W + K_W)'(MAX_SEC);

	localparam int LATENCY = 3 + DIV_STAGES + 6;

	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_MUL = 3'd2;
	localparam logic [2:0] OP_DIV = 3'd3;
	localparam logic [2:0] OP_CMP = 3'd4;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_INVALID = 3'd1;
	localparam logic [2:0] ST_DIVZERO = 3'd2;
	localparam logic [2:0] ST_UNDER = 3'd3;
	localparam logic [2:0] ST_OVER = 3'd4;

	typedef struct packed {
		logic [2:0]  op;
		logic [15:0] a_day;
		logic [4:0]  a_hour;
		logic [5:0]  a_minute;
		logic [5:0]  a_second;
		logic [15:0] b_day;
		logic [4:0]  b_hour;
		logic [5:0]  b_minute;
		logic [5:0]  b_second;
		logic [15:0] factor;
	} req_t;

	typedef struct packed {
		logic [15:0] res_day;
		logic [4:0]  res_hour;
		logic [5:0]  res_minute;
		logic [5:0]  res_second;
		logic        is_less;
		logic        is_equal;
		logic        is_greater;
		logic [2:0]  status;
	} rsp_t;

	typedef struct packed {
		logic        lt;
		logic        eq;
		logic        gt;
	} cmp_t;

	// front stage result
	typedef struct packed {
		logic [2:0]       op;
		logic [SEC_W-1:0] ta;
		logic [SEC_W-1:0] tb;
		logic [K_W-1:0]   k;
		logic             invalid;
		cmp_t             cmp;
	} front_t;

	// travels alongside the divider
	typedef struct packed {
		logic [SEC_W-1:0] n;
		logic [2:0]       st;
		logic             is_div;
		cmp_t             cmp;
	} side_t;

	function automatic logic [SEC_W-1:0] dur_sec(logic [15:0] d, logic [4:0] h,
			logic [5:0] m, logic [5:0] s);
		logic [SEC_W-1:0] acc;
		acc = {{(SEC_W-16){1'b0}}, d} * SEC_W'(SEC_PER_DAY);
		acc = acc + {{(SEC_W-5){1'b0}}, h} * SEC_W'(3600);
		acc = acc + {{(SEC_W-6){1'b0}}, m} * SEC_W'(60);
		acc = acc + {{(SEC_W-6){1'b0}}, s};
		return acc;
	endfunction

endpackage

// File: rtl/core/dau_front.sv
// Front stage: field checks, comparison and conversion to total seconds.
`timescale 1ns / 1ps
module dau_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_vld,
	input  dau_pkg::req_t   req,
	output logic            vld_s1,
	output dau_pkg::front_t fr_s1
);

	logic a_ok, b_ok, chk_b, bad;
	logic [32:0] ka, kb;

	always_comb begin
		a_ok = (64'(req.a_day) < dau_pkg::DAY_LIMIT) && (req.a_hour < 5'd24)
			&& (req.a_minute < 6'd60) && (req.a_second < 6'd60);
		b_ok = (64'(req.b_day) < dau_pkg::DAY_LIMIT) && (req.b_hour < 5'd24)
			&& (req.b_minute < 6'd60) && (req.b_second < 6'd60);
		chk_b = (req.op == dau_pkg::OP_ADD) || (req.op == dau_pkg::OP_SUB)
			|| (req.op == dau_pkg::OP_CMP);
		bad = (req.op > dau_pkg::OP_CMP) || !a_ok || (chk_b && !b_ok);
		// lexicographic order is plain numeric order of the joined fields
		ka = {req.a_day, req.a_hour, req.a_minute, req.a_second};
		kb = {req.b_day, req.b_hour, req.b_minute, req.b_second};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		fr_s1.op <= req.op;
		fr_s1.ta <= dau_pkg::dur_sec(req.a_day, req.a_hour, req.a_minute, req.a_second);
		fr_s1.tb <= dau_pkg::dur_sec(req.b_day, req.b_hour, req.b_minute, req.b_second);
		fr_s1.k <= req.factor;
		fr_s1.invalid <= bad;
		fr_s1.cmp.lt <= ka < kb;
		fr_s1.cmp.eq <= ka == kb;
		fr_s1.cmp.gt <= ka > kb;
	end

endmodule

// File: rtl/core/dau_alu.sv
// Add, subtract and multiply stages with range checks and status priority.
`timescale 1ns / 1ps
module dau_alu (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      vld_s1,
	input  dau_pkg::front_t           fr_s1,
	output logic                      vld_s3,
	output dau_pkg::side_t            side_s3,
	output logic [dau_pkg::SEC_W-1:0] ta_s3,
	output logic [dau_pkg::K_W-1:0]   k_s3
);

	localparam int SW = dau_pkg::SEC_W;
	localparam int KW = dau_pkg::K_W;

	logic              vld_s2;
	dau_pkg::front_t   fr_s2;
	logic [SW:0]       sum_s2;
	logic [SW-1:0]     diff_s2;
	logic              under_s2;
	logic [SW+KW-1:0]  prod_s2;
	dau_pkg::side_t    side_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		fr_s2 <= fr_s1;
		sum_s2 <= {1'b0, fr_s1.ta} + {1'b0, fr_s1.tb};
		diff_s2 <= fr_s1.ta - fr_s1.tb;
		under_s2 <= fr_s1.tb > fr_s1.ta;
		prod_s2 <= {{KW{1'b0}}, fr_s1.ta} * {{SW{1'b0}}, fr_s1.k};
	end

	always_comb begin
		side_nx.n = '0;
		side_nx.st = dau_pkg::ST_OK;
		side_nx.is_div = 1'b0;
		side_nx.cmp = fr_s2.cmp;
		if (fr_s2.invalid) begin
			side_nx.st = dau_pkg::ST_INVALID;
		end else begin
			case (fr_s2.op)
				dau_pkg::OP_ADD: begin
					if (sum_s2 > dau_pkg::MAX_WIDE[SW:0]) begin
						side_nx.st = dau_pkg::ST_OVER;
					end else begin
						side_nx.n = sum_s2[SW-1:0];
					end
				end
				dau_pkg::OP_SUB: begin
					if (under_s2) begin
						side_nx.st = dau_pkg::ST_UNDER;
					end else begin
						side_nx.n = diff_s2;
					end
				end
				dau_pkg::OP_MUL: begin
					if (prod_s2 > dau_pkg::MAX_WIDE) begin
						side_nx.st = dau_pkg::ST_OVER;
					end else begin
						side_nx.n = prod_s2[SW-1:0];
					end
				end
				dau_pkg::OP_DIV: begin
					if (fr_s2.k == '0) begin
						side_nx.st = dau_pkg::ST_DIVZERO;
					end else begin
						side_nx.is_div = 1'b1;
					end
				end
				default: begin
					side_nx.n = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		side_s3 <= side_nx;
		ta_s3 <= fr_s2.ta;
		k_s3 <= fr_s2.k;
	end

endmodule

// File: rtl/core/dau_div.sv
// Pipelined restoring divider, a few quotient bits per stage.
`timescale 1ns / 1ps
module dau_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_vld,
	input  logic [dau_pkg::SEC_W-1:0] dividend,
	input  logic [dau_pkg::K_W-1:0]   divisor,
	input  dau_pkg::side_t            side_in,
	output logic                      out_vld,
	output logic [dau_pkg::SEC_W-1:0] quotient,
	output dau_pkg::side_t            side_out
);

	localparam int NS = dau_pkg::DIV_STAGES;
	localparam int QW = dau_pkg::DIV_QW;
	localparam int KW = dau_pkg::K_W;
	localparam int SW = dau_pkg::SEC_W;

	logic [NS:0]    vld_s;
	logic [KW-1:0]  rem_s [0:NS];
	logic [QW-1:0]  wrk_s [0:NS];
	logic [KW-1:0]  dvs_s [0:NS];
	dau_pkg::side_t sd_s  [0:NS];

	assign vld_s[0] = in_vld;
	assign rem_s[0] = '0;
	assign wrk_s[0] = {{(QW-SW){1'b0}}, dividend};
	assign dvs_s[0] = divisor;
	assign sd_s[0] = side_in;

	for (genvar g = 0; g < NS; g++) begin : g_stage
		logic [KW-1:0] rem_nx;
		logic [QW-1:0] wrk_nx;

		always_comb begin
			logic [KW:0]   t;
			logic [KW-1:0] r;
			logic [QW-1:0] w;
			r = rem_s[g];
			w = wrk_s[g];
			for (int j = 0; j < dau_pkg::DIV_STEP; j++) begin
				t = {r, w[QW-1]};
				w = {w[QW-2:0], 1'b0};
				if (t >= {1'b0, dvs_s[g]}) begin
					t = t - {1'b0, dvs_s[g]};
					w[0] = 1'b1;
				end
				r = t[KW-1:0];
			end
			rem_nx = r;
			wrk_nx = w;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else begin
				vld_s[g+1] <= vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[g+1] <= rem_nx;
			wrk_s[g+1] <= wrk_nx;
			dvs_s[g+1] <= dvs_s[g];
			sd_s[g+1] <= sd_s[g];
		end
	end

	assign out_vld = vld_s[NS];
	assign quotient = wrk_s[NS][SW-1:0];
	assign side_out = sd_s[NS];

endmodule

// File: rtl/core/dau_split.sv
// Splits total seconds into days, hours, minutes and seconds by reciprocal division.
`timescale 1ns / 1ps
module dau_split (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_vld,
	input  logic [dau_pkg::SEC_W-1:0] n,
	input  logic [2:0]                st,
	input  dau_pkg::cmp_t             cmp,
	output logic                      out_vld,
	output dau_pkg::rsp_t             rsp
);

	localparam int SW = dau_pkg::SEC_W;
	localparam int MW = dau_pkg::M1_W;
	localparam int HW = dau_pkg::H1_W;
	localparam int DW = dau_pkg::DQ_W;

	typedef struct packed {
		logic [2:0]    st;
		dau_pkg::cmp_t cmp;
	} tag_t;

	logic [5:0] vld_s;
	tag_t       tag_s1, tag_s2, tag_s3, tag_s4, tag_s5;

	logic [SW-1:0] n_s1, q_s1;
	logic [MW-1:0] m1_s2, m1_s3, qm_s3;
	logic [5:0]    sec_s2, sec_s3, sec_s4, sec_s5;
	logic [HW-1:0] h1_s4, h1_s5, qh_s5;
	logic [5:0]    min_s4, min_s5;

	logic [2*SW-1:0] pn;
	logic [2*MW-1:0] pm;
	logic [2*HW-1:0] ph;
	logic [6:0]      rn, rm;
	logic [4:0]      rh;
	logic            cn, cm, ch;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[4:0], in_vld};
		end
	end

	always_comb begin
		pn = {{SW{1'b0}}, n} * {{SW{1'b0}}, dau_pkg::R60_N};
		pm = {{MW{1'b0}}, m1_s2} * {{MW{1'b0}}, dau_pkg::R60_M};
		ph = {{HW{1'b0}}, h1_s4} * {{HW{1'b0}}, dau_pkg::R24_H};
		// estimates are low by at most one: one compare and subtract fixes them
		rn = n_s1[6:0] - 7'(q_s1 * 7'd60);
		cn = rn >= 7'd60;
		rm = m1_s3[6:0] - 7'(qm_s3 * 7'd60);
		cm = rm >= 7'd60;
		rh = h1_s5[4:0] - 5'(qh_s5 * 5'd24);
		ch = rh >= 5'd24;
	end

	always_ff @(posedge clk) begin
		n_s1 <= n;
		q_s1 <= pn[2*SW-1:SW];
		tag_s1 <= {st, cmp};

		m1_s2 <= q_s1[MW-1:0] + {{(MW-1){1'b0}}, cn};
		sec_s2 <= cn ? 6'(rn - 7'd60) : rn[5:0];
		tag_s2 <= tag_s1;

		m1_s3 <= m1_s2;
		qm_s3 <= pm[2*MW-1:MW];
		sec_s3 <= sec_s2;
		tag_s3 <= tag_s2;

		h1_s4 <= qm_s3[HW-1:0] + {{(HW-1){1'b0}}, cm};
		min_s4 <= cm ? 6'(rm - 7'd60) : rm[5:0];
		sec_s4 <= sec_s3;
		tag_s4 <= tag_s3;

		h1_s5 <= h1_s4;
		qh_s5 <= ph[2*HW-1:HW];
		min_s5 <= min_s4;
		sec_s5 <= sec_s4;
		tag_s5 <= tag_s4;

		rsp.res_day <= 16'(qh_s5[DW-1:0] + {{(DW-1){1'b0}}, ch});
		rsp.res_hour <= ch ? 5'(rh - 5'd24) : rh;
		rsp.res_minute <= min_s5;
		rsp.res_second <= sec_s5;
		rsp.is_less <= tag_s5.cmp.lt;
		rsp.is_equal <= tag_s5.cmp.eq;
		rsp.is_greater <= tag_s5.cmp.gt;
		rsp.status <= tag_s5.st;
	end

	assign out_vld = vld_s[5];

endmodule

// File: rtl/core/duration_arithmetic_unit.sv
// Top level of the duration arithmetic unit.
`timescale 1ns / 1ps
// A request passes the front, ALU, 3-bit-per-stage divider and split stages in turn
// before its result strobe.
// Throughput: one request per cycle; busy never rises, as nothing in the pipe waits.
// Results come out in request order, each on done for exactly one cycle.
// Reset clears every valid bit at once; data registers are not reset.
module duration_arithmetic_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  dau_pkg::req_t req,
	output logic          done,
	output dau_pkg::rsp_t res
);

	logic                      take;
	logic                      vld_s1, vld_s3, dv_vld;
	dau_pkg::front_t           fr_s1;
	dau_pkg::side_t            side_s3, dv_side;
	logic [dau_pkg::SEC_W-1:0] ta_s3, dv_q, n_mg;
	logic [dau_pkg::K_W-1:0]   k_s3;

	// the receiver cannot refuse, so the pipe never stalls
	assign busy = 1'b0;
	assign take = start && !busy;

	// stage 1: check fields, compare A with B, convert to seconds
	dau_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_vld (take),
		.req    (req),
		.vld_s1 (vld_s1),
		.fr_s1  (fr_s1)
	);

	// stages 2 and 3: add, subtract, multiply, then resolve status
	dau_alu u_alu (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_s1  (vld_s1),
		.fr_s1   (fr_s1),
		.vld_s3  (vld_s3),
		.side_s3 (side_s3),
		.ta_s3   (ta_s3),
		.k_s3    (k_s3)
	);

	// every request runs through the divider so all paths share one latency
	dau_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s3),
		.dividend (ta_s3),
		.divisor  (k_s3),
		.side_in  (side_s3),
		.out_vld  (dv_vld),
		.quotient (dv_q),
		.side_out (dv_side)
	);

	// take the quotient only for a good divide; other paths already hold zero on error
	assign n_mg = dv_side.is_div ? dv_q : dv_side.n;

	dau_split u_split (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (dv_vld),
		.n       (n_mg),
		.st      (dv_side.st),
		.cmp     (dv_side.cmp),
		.out_vld (done),
		.rsp     (res)
	);

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> ##(dau_pkg::LATENCY) done)
		else $error("result strobe missing after request");

	a_no_ghost: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(take, dau_pkg::LATENCY))
		else $error("result strobe without request");

	a_one_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $onehot({res.is_less, res.is_equal, res.is_greater}))
		else $error("compare flags not exclusive");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && res.status != dau_pkg::ST_OK) |-> (res.res_day == '0
			&& res.res_hour == '0 && res.res_minute == '0 && res.res_second == '0))
		else $error("nonzero result on error");

	a_ranges: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (res.res_hour < 5'd24 && res.res_minute < 6'd60
			&& res.res_second < 6'd60))
		else $error("result field out of range");

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench of the duration arithmetic unit.
`timescale 1ns / 1ps
module tb;
	import dau_pkg::*;

	localparam longint unsigned SEC_DAY = 64'd86400;
	localparam longint unsigned SEC_MAX = (64'd1 << 16) * SEC_DAY - 64'd1;

	logic  clk;
	logic  arst_n;
	logic  start;
	logic  busy;
	req_t  req;
	logic  done;
	rsp_t  res;

	rsp_t  expected_q[$];
	int    fail_count;

	duration_arithmetic_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.res(res)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Work out the result of one request on total seconds.
	function automatic rsp_t predict_duration(req_t r);
		rsp_t             o;
		logic             a_ok;
		logic             b_ok;
		logic [2:0]       st;
		longint unsigned  ta;
		longint unsigned  tb;
		longint unsigned  n;
		a_ok = r.a_hour < 24 && r.a_minute < 60 && r.a_second < 60;
		b_ok = r.b_hour < 24 && r.b_minute < 60 && r.b_second < 60;
		ta = r.a_day * SEC_DAY + r.a_hour * 3600 + r.a_minute * 60 + r.a_second;
		tb = r.b_day * SEC_DAY + r.b_hour * 3600 + r.b_minute * 60 + r.b_second;
		st = ST_OK;
		n = 0;
		o = '0;
		if ({r.a_day, r.a_hour, r.a_minute, r.a_second} <
				{r.b_day, r.b_hour, r.b_minute, r.b_second})
			o.is_less = 1'b1;
		else if ({r.a_day, r.a_hour, r.a_minute, r.a_second} >
				{r.b_day, r.b_hour, r.b_minute, r.b_second})
			o.is_greater = 1'b1;
		else
			o.is_equal = 1'b1;
		if (r.op > OP_CMP || !a_ok || ((r.op <= OP_SUB || r.op == OP_CMP) && !b_ok)) begin
			st = ST_INVALID;
		end else begin
			case (r.op)
				OP_ADD: begin
					n = ta + tb;
					if (n > SEC_MAX)
						st = ST_OVER;
				end
				OP_SUB: begin
					if (tb > ta)
						st = ST_UNDER;
					else
						n = ta - tb;
				end
				OP_MUL: begin
					if (r.factor != 0 && ta > SEC_MAX / r.factor)
						st = ST_OVER;
					else
						n = ta * r.factor;
				end
				OP_DIV: begin
					if (r.factor == 0)
						st = ST_DIVZERO;
					else
						n = ta / r.factor;
				end
				default: ;
			endcase
		end
		if (st != ST_OK || r.op == OP_CMP)
			n = 0;
		o.res_day = 16'(n / SEC_DAY);
		o.res_hour = 5'((n / 3600) % 24);
		o.res_minute = 6'((n / 60) % 60);
		o.res_second = 6'(n % 60);
		o.status = st;
		return o;
	endfunction

	// Compare every strobed result with the oldest prediction.
	always @(posedge clk) begin
		rsp_t e;
		if (arst_n && done) begin
			if (expected_q.size() == 0) begin
				$error("result with no request outstanding");
				fail_count++;
			end else begin
				e = expected_q.pop_front();
				if (res.res_day !== e.res_day) begin
					$error("res_day exp %0d got %0d", e.res_day, res.res_day);
					fail_count++;
				end
				if (res.res_hour !== e.res_hour) begin
					$error("res_hour exp %0d got %0d", e.res_hour, res.res_hour);
					fail_count++;
				end
				if (res.res_minute !== e.res_minute) begin
					$error("res_minute exp %0d got %0d", e.res_minute, res.res_minute);
					fail_count++;
				end
				if (res.res_second !== e.res_second) begin
					$error("res_second exp %0d got %0d", e.res_second, res.res_second);
					fail_count++;
				end
				if (res.is_less !== e.is_less) begin
					$error("is_less exp %0d got %0d", e.is_less, res.is_less);
					fail_count++;
				end
				if (res.is_equal !== e.is_equal) begin
					$error("is_equal exp %0d got %0d", e.is_equal, res.is_equal);
					fail_count++;
				end
				if (res.is_greater !== e.is_greater) begin
					$error("is_greater exp %0d got %0d", e.is_greater, res.is_greater);
					fail_count++;
				end
				if (res.status !== e.status) begin
					$error("status exp %0d got %0d", e.status, res.status);
					fail_count++;
				end
			end
		end
	end

	// Hold one request on the ports until the unit takes it; drop start only
	// for an idle gap. Back-to-back requests keep start high with no extra edge.
	int burst_left;

	task automatic send_request(req_t r);
		int gap;
		if (burst_left == 0) begin
			// idle gap before a new burst
			gap = ($urandom_range(0, 6) == 0) ? int'($urandom_range(1, 12)) : 0;
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		start <= 1'b1;
		req <= r;
		do
			@(posedge clk);
		while (busy);
		expected_q.push_back(predict_duration(r));
		burst_left--;
	endtask

	task automatic park_sender();
		start <= 1'b0;
		burst_left = 0;
		@(posedge clk);
	endtask

	function automatic req_t random_valid(logic [2:0] op);
		req_t r;
		r = '0;
		r.op = op;
		r.a_day = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
		r.a_hour = 5'($urandom_range(0, 23));
		r.a_minute = 6'($urandom_range(0, 59));
		r.a_second = 6'($urandom_range(0, 59));
		r.b_day = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
		r.b_hour = 5'($urandom_range(0, 23));
		r.b_minute = 6'($urandom_range(0, 59));
		r.b_second = 6'($urandom_range(0, 59));
		case ($urandom_range(0, 3))
			0: r.factor = 16'($urandom);
			1: r.factor = 16'($urandom_range(0, 3));
			default: r.factor = 16'($urandom_range(0, 300));
		endcase
		// often make B a near copy of A to hit equal and borderline differences
		if ($urandom_range(0, 4) == 0) begin
			{r.b_day, r.b_hour, r.b_minute} = {r.a_day, r.a_hour, r.a_minute};
			if ($urandom_range(0, 1))
				r.b_second = r.a_second;
		end
		return r;
	endfunction

	// Extremes of the fields, every operation and every status.
	task automatic test_directed();
		req_t r;
		r = '0;
		r.op = OP_ADD;
		send_request(r);
		r = '{OP_ADD, 16'hFFFF, 5'd23, 6'd59, 6'd59, 16'd0, 5'd0, 6'd0, 6'd1, 16'd0};
		send_request(r);
		r = '{OP_ADD, 16'hFFFF, 5'd23, 6'd59, 6'd59, 16'd0, 5'd0, 6'd0, 6'd0, 16'd0};
		send_request(r);
		r = '{OP_SUB, 16'd5, 5'd1, 6'd2, 6'd3, 16'd5, 5'd1, 6'd2, 6'd3, 16'd0};
		send_request(r);
		r = '{OP_SUB, 16'd5, 5'd1, 6'd2, 6'd3, 16'd5, 5'd1, 6'd2, 6'd4, 16'd0};
		send_request(r);
		r = '{OP_SUB, 16'hFFFF, 5'd23, 6'd59, 6'd59, 16'd0, 5'd0, 6'd0, 6'd0, 16'd0};
		send_request(r);
		r = '{OP_MUL, 16'd3, 5'd4, 6'd5, 6'd6, 16'd0, 5'd0, 6'd0, 6'd0, 16'd0};
		send_request(r);
		r = '{OP_MUL, 16'd3, 5'd4, 6'd5, 6'd6, 16'd0, 5'd0, 6'd0, 6'd0, 16'hFFFF};
		send_request(r);
		r = '{OP_MUL, 16'd0, 5'd0, 6'd0, 6'd1, 16'd0, 5'd0, 6'd0, 6'd0, 16'hFFFF};
		send_request(r);
		r = '{OP_DIV, 16'hFFFF, 5'd23, 6'd59, 6'd59, 16'd0, 5'd0, 6'd0, 6'd0, 16'd0};
		send_request(r);
		r = '{OP_DIV, 16'hFFFF, 5'd23, 6'd59, 6'd59, 16'd0, 5'd0, 6'd0, 6'd0, 16'd1};
		send_request(r);
		r = '{OP_DIV, 16'hFFFF, 5'd23, 6'd59, 6'd59, 16'd0, 5'd0, 6'd0, 6'd0, 16'hFFFF};
		send_request(r);
		// multiply and divide ignore an invalid B
		r = '{OP_DIV, 16'd1, 5'd0, 6'd0, 6'd0, 16'd0, 5'd31, 6'd63, 6'd63, 16'd7};
		send_request(r);
		r = '{OP_CMP, 16'd2, 5'd3, 6'd4, 6'd5, 16'd2, 5'd3, 6'd5, 6'd0, 16'd0};
		send_request(r);
		r = '{OP_CMP, 16'd2, 5'd3, 6'd4, 6'd5, 16'd0, 5'd24, 6'd0, 6'd0, 16'd0};
		send_request(r);
		r = '{OP_ADD, 16'd0, 5'd31, 6'd0, 6'd0, 16'd0, 5'd0, 6'd0, 6'd0, 16'd0};
		send_request(r);
		r = '{OP_SUB, 16'd0, 5'd0, 6'd63, 6'd0, 16'd0, 5'd0, 6'd0, 6'd0, 16'd0};
		send_request(r);
		r = '{OP_MUL, 16'd0, 5'd0, 6'd0, 6'd60, 16'd0, 5'd0, 6'd0, 6'd0, 16'd2};
		send_request(r);
		r = '{3'd5, 16'd1, 5'd1, 6'd1, 6'd1, 16'd1, 5'd1, 6'd1, 6'd1, 16'd1};
		send_request(r);
		r = '{3'd7, 16'hFFFF, 5'd31, 6'd63, 6'd63, 16'hFFFF, 5'd31, 6'd63, 6'd63, 16'hFFFF};
		send_request(r);
		park_sender();
	endtask

	// Mostly well-formed durations, with some raw noise in every bit.
	task automatic test_random(int count);
		req_t r;
		repeat (count) begin
			if ($urandom_range(0, 9) == 0)
				r = req_t'({$urandom, $urandom, $urandom});
			else
				r = random_valid(3'($urandom_range(0, 4)));
			send_request(r);
		end
		park_sender();
	endtask

	initial begin
		int spin;
		fail_count = 0;
		burst_left = 0;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(1300);
		spin = 0;
		while (expected_q.size() != 0 && spin < 1000) begin
			@(posedge clk);
			spin++;
		end
		repeat (LATENCY + 5) @(posedge clk);
		if (fail_count == 0 && expected_q.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Watchdog.
	initial begin
		#200000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
